// ===== design/psg_pkg.sv =====
// psg_pkg: shared types, register indexes and the volume table for the sound generator
// no dependencies; imported by every module in design/

package psg_pkg;

  // bus item kinds carried in tuser
  typedef enum logic [1:0] {
    FUNC_LATCH = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  // register indexes
  localparam logic [3:0] REG_NOISE_PER = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_VOL_A     = 4'd8;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  localparam int NUM_CH = 3;

  // control from the top to the envelope generator
  typedef struct packed {
    logic tick;
    logic shape_wr;
    logic wr_attack;
  } env_ctrl_t;

  // log-style volume table
  function automatic logic [5:0] vol_lookup(input logic [3:0] v);
    logic [5:0] r;
    begin
      case (v)
        4'd0:    r = 6'd0;
        4'd1:    r = 6'd1;
        4'd2:    r = 6'd2;
        4'd3:    r = 6'd3;
        4'd4:    r = 6'd4;
        4'd5:    r = 6'd5;
        4'd6:    r = 6'd7;
        4'd7:    r = 6'd10;
        4'd8:    r = 6'd13;
        4'd9:    r = 6'd18;
        4'd10:   r = 6'd24;
        4'd11:   r = 6'd30;
        4'd12:   r = 6'd36;
        4'd13:   r = 6'd40;
        default: r = 6'd42;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== design/psg_tone_noise_envelope.sv =====
// psg_tone_noise_envelope: top level of the three-channel sound generator
// depends on psg_pkg, psg_tone, psg_noise, psg_env
//
// usage
//   input channel s_*: one word per bus access or tick. tuser carries the
//   kind (latch address, write data, read data, tick) and tdata the byte.
//   output channel m_*: exactly one word per input word, in order, holding
//   the read data (zero unless a read) and the signed mixed amplitude seen
//   after that word took effect.
// timing
//   a word is held in the input register, then the state update and
//   mix are computed in a single pass into the output register: m_tvalid
//   rises when the word leaves the input register, which it cannot do
//   while the output is stalled. one word per cycle sustained while
//   m_tready stays high, as each divider updates counter and compare in that pass.
// reset
//   rst (synchronous, active high) clears the register file, address latch,
//   all dividers, the lfsr (to one) and the envelope; both stages go empty.
// stall
//   when m_tready is low the result stays in the output register; one more
//   word can wait in the input register, after which s_tready drops.

module psg_tone_noise_envelope
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // [7:0] bus_data
  input  logic [1:0]  s_tuser,  // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [7:0] read_data, [15:8] amplitude
);

  // input register
  logic       in_valid;
  func_t      in_func;
  logic [7:0] in_data;
  logic       advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func <= func_t'(s_tuser);
      in_data <= s_tdata;
    end
  end

  // decoded item
  logic do_latch;
  logic do_write;
  logic do_read;
  logic do_tick;

  always_comb begin
    do_latch = 1'b0;
    do_write = 1'b0;
    do_read  = 1'b0;
    do_tick  = 1'b0;
    unique case (in_func)
      FUNC_LATCH: do_latch = advance;
      FUNC_WRITE: do_write = advance;
      FUNC_READ:  do_read  = advance;
      FUNC_TICK:  do_tick  = advance;
      default:    do_tick  = 1'b0;
    endcase
  end

  // register file and address latch
  logic [7:0] regs [16];
  logic [3:0] addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      for (int i = 0; i < 16; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (do_latch) begin
        addr <= in_data[3:0];
      end
      if (do_write) begin
        regs[addr] <= in_data;
      end
    end
  end

  // register values after this word, for the mix
  function automatic logic [7:0] reg_after(input logic [3:0] idx, input logic [7:0] cur,
                                           input logic wr, input logic [3:0] a,
                                           input logic [7:0] d);
    begin
      return (wr && a == idx) ? d : cur;
    end
  endfunction

  // tone channels; a zero period counts as one
  logic [NUM_CH-1:0] tone_level_next;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_tone
    logic [11:0] raw_per;
    logic [11:0] per;
    assign raw_per = {regs[2*c+1][3:0], regs[2*c]};
    assign per     = (raw_per == 12'd0) ? 12'd1 : raw_per;
    psg_tone u_tone (
      .clk        (clk),
      .rst        (rst),
      .tick       (do_tick),
      .period     (per),
      .level_next (tone_level_next[c])
    );
  end

  // noise
  logic [4:0] noise_per;
  logic       noise_level_next;

  assign noise_per = (regs[REG_NOISE_PER][4:0] == 5'd0) ? 5'd1 : regs[REG_NOISE_PER][4:0];

  psg_noise u_noise (
    .clk        (clk),
    .rst        (rst),
    .tick       (do_tick),
    .period     (noise_per),
    .level_next (noise_level_next)
  );

  // envelope; a shape write restarts it
  env_ctrl_t   env_ctrl;
  logic [15:0] env_raw;
  logic [15:0] env_per;
  logic [3:0]  env_level_next;

  assign env_ctrl.tick      = do_tick;
  assign env_ctrl.shape_wr  = do_write && addr == REG_ENV_SHAPE;
  assign env_ctrl.wr_attack = in_data[2];
  assign env_raw            = {regs[REG_ENV_HI], regs[REG_ENV_LO]};
  assign env_per            = (env_raw == 16'd0) ? 16'd1 : env_raw;

  psg_env u_env (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (env_ctrl),
    .period     (env_per),
    .shape      (regs[REG_ENV_SHAPE][3:0]),
    .level_next (env_level_next)
  );

  // mixer: each channel adds +vol when its gate is open, else -vol
  logic [7:0]        mixer_next;
  logic signed [7:0] amp;
  logic [7:0]        rd;

  assign mixer_next = reg_after(REG_MIXER, regs[REG_MIXER], do_write, addr, in_data);

  always_comb begin
    logic [7:0]        vr;
    logic [3:0]        v;
    logic              gate;
    logic signed [7:0] a;
    amp = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      vr   = reg_after(REG_VOL_A + 4'(c), regs[REG_VOL_A + 4'(c)], do_write, addr, in_data);
      v    = vr[4] ? env_level_next : vr[3:0];
      gate = (mixer_next[c] || tone_level_next[c]) && (mixer_next[c+3] || noise_level_next);
      a    = signed'({2'b00, vol_lookup(v)});
      amp  = gate ? amp + a : amp - a;
    end
  end

  assign rd = do_read ? regs[addr] : 8'd0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {amp, rd};
    end
  end

endmodule

// ===== design/psg_tone.sv =====
// psg_tone: one 12-bit tone divider toggling a square level
// depends on psg_pkg

module psg_tone
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,
  input  logic [11:0] period,
  output logic        level_next
);

  logic [11:0] counter;
  logic [11:0] counter_next;
  logic [11:0] counter_inc;
  logic        level;
  logic        wrap;

  assign counter_inc = counter + 12'd1;
  assign wrap        = counter_inc >= period;

  always_comb begin
    counter_next = counter;
    level_next   = level;
    if (tick) begin
      counter_next = wrap ? 12'd0 : counter_inc;
      level_next   = level ^ wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      level   <= 1'b0;
    end else begin
      counter <= counter_next;
      level   <= level_next;
    end
  end

endmodule

// ===== design/psg_noise.sv =====
// psg_noise: 5-bit noise divider clocking a 17-bit lfsr
// depends on psg_pkg

module psg_noise
  import psg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic [4:0] period,
  output logic       level_next
);

  logic [5:0]  counter;
  logic [5:0]  counter_next;
  logic [5:0]  counter_inc;
  logic [16:0] shift;
  logic [16:0] shift_next;
  logic        level;
  logic        wrap;

  assign counter_inc = counter + 6'd1;
  assign wrap        = counter_inc >= {period, 1'b0};

  always_comb begin
    counter_next = counter;
    shift_next   = shift;
    level_next   = level;
    if (tick) begin
      counter_next = wrap ? 6'd0 : counter_inc;
      if (wrap) begin
        shift_next = {shift[0] ^ shift[3], shift[16:1]};
        level_next = shift_next[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      shift   <= 17'd1;
      level   <= 1'b0;
    end else begin
      counter <= counter_next;
      shift   <= shift_next;
      level   <= level_next;
    end
  end

endmodule

// ===== design/psg_env.sv =====
// psg_env: envelope divider and step counter with continue, attack, alternate, hold
// depends on psg_pkg (env_ctrl_t)

module psg_env
  import psg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  env_ctrl_t   ctrl,
  input  logic [15:0] period,
  input  logic [3:0]  shape,
  output logic [3:0]  level_next
);

  logic [20:0] counter;
  logic [20:0] counter_next;
  logic [20:0] counter_inc;
  logic [4:0]  step;
  logic [4:0]  step_next;
  logic        rising;
  logic        rising_next;
  logic [3:0]  level;
  logic        wrap;
  logic        cont;
  logic        attack;
  logic        alt;
  logic        hold;

  assign cont   = shape[3];
  assign attack = shape[2];
  assign alt    = shape[1];
  assign hold   = shape[0];

  assign counter_inc = counter + 21'd1;
  assign wrap        = counter_inc >= {period, 5'b0};

  always_comb begin
    counter_next = counter;
    step_next    = step;
    rising_next  = rising;
    level_next   = level;
    if (ctrl.shape_wr) begin
      counter_next = '0;
      step_next    = '0;
      rising_next  = ctrl.wr_attack;
      level_next   = ctrl.wr_attack ? 4'd0 : 4'd15;
    end else if (ctrl.tick) begin
      counter_next = wrap ? 21'd0 : counter_inc;
      if (wrap) begin
        if (!step[4]) begin
          level_next = rising ? step[3:0] : ~step[3:0];
          step_next  = step + 5'd1;
        end else if (!cont) begin
          level_next = 4'd0;
        end else if (hold) begin
          level_next = (rising ^ alt) ? 4'd15 : 4'd0;
        end else begin
          rising_next = rising ^ alt;
          step_next   = '0;
          level_next  = rising_next ? 4'd0 : 4'd15;
        end
      end
    end
  end

  // attack acts through ctrl.wr_attack at a shape write, the stored bit is not read
  logic unused_attack;
  assign unused_attack = attack;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      step    <= '0;
      rising  <= 1'b0;
      level   <= '0;
    end else begin
      counter <= counter_next;
      step    <= step_next;
      rising  <= rising_next;
      level   <= level_next;
    end
  end

endmodule
